@@ design/tdrd_pkg.sv @@
// ----------------------------------------------------------------------------
// tdrd_pkg : shared definitions for the turtle dead-reckoning distance unit
// Command codes, trig table, turn reciprocal and the controller/datapath link.
// ----------------------------------------------------------------------------
package tdrd_pkg;

  // default configuration
  localparam int FRAC_BITS_DEF   = 16;
  localparam int AMOUNT_BITS_DEF = 16;
  localparam int POS_BITS_DEF    = 48;

  // fixed field widths
  localparam int REQ_W    = 2;
  localparam int AMT_W    = 16;
  localparam int DIST_W   = 32;
  localparam int HEAD_W   = 9;
  localparam int TRIG_W   = 17;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = AMT_W + MUL_B_W;

  // angles in degrees
  localparam int HALF_TURN    = 180;
  localparam int FULL_TURN    = 2 * HALF_TURN;
  localparam int QUARTER_TURN = HALF_TURN / 2;

  // amount / 360 as a multiply by a rounded-up reciprocal; exact for 16-bit amounts
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_VAL   = ((1 << RECIP_SHIFT) + FULL_TURN - 1) / FULL_TURN;
  localparam int QUOT_W      = 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_FWD   = 2'd0,
    REQ_BACK  = 2'd1,
    REQ_LEFT  = 2'd2,
    REQ_RIGHT = 2'd3
  } req_e;

  // quarter-wave sine, Q1.16
  localparam logic [TRIG_W-1:0] SINE_ROM [0:QUARTER_TURN] = '{
    17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
    17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
    17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
    17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
    17'd30767, 17'd31772, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
    17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
    17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
    17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
    17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
    17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
    17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
    17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048,
    17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
  };

  typedef struct packed {
    logic                neg;
    logic [TRIG_W-1:0]   mag;
  } trig_t;

  // signed sine of an angle 0..359
  function automatic trig_t trig_lookup(input logic [HEAD_W-1:0] deg);
    trig_t             res;
    logic [HEAD_W-1:0] rem;
    logic [1:0]        quad;
    logic [6:0]        idx;
    if (deg >= HEAD_W'(3 * QUARTER_TURN)) begin
      quad = 2'd3;
      rem  = deg - HEAD_W'(3 * QUARTER_TURN);
    end else if (deg >= HEAD_W'(HALF_TURN)) begin
      quad = 2'd2;
      rem  = deg - HEAD_W'(HALF_TURN);
    end else if (deg >= HEAD_W'(QUARTER_TURN)) begin
      quad = 2'd1;
      rem  = deg - HEAD_W'(QUARTER_TURN);
    end else begin
      quad = 2'd0;
      rem  = deg;
    end
    idx = quad[0] ? (7'(QUARTER_TURN) - rem[6:0]) : rem[6:0];
    res.mag = SINE_ROM[idx];
    res.neg = quad[1];
    return res;
  endfunction

  // controller -> datapath
  typedef struct packed {
    logic load_in;     // capture amount, look up cosine
    logic trig_sin;    // look up sine
    logic mul_trig;    // product <= amount * trig
    logic mul_recip;   // product <= amount * reciprocal of 360
    logic add_x;       // saturating add of product into x
    logic add_y;       // saturating add of product into y
    logic negate;      // move is backwards
    logic turn_left;
    logic turn_right;
    logic sq_load;     // start sum of squares
    logic sq_step;
    logic rt_load;     // start square root
    logic rt_step;
    logic out_load;    // round into output register, clear state
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic step_last;   // iteration counter at its final step
  } dp_status_t;

endpackage

@@ design/tdrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// tdrd_ctrl : sequencer of the turtle dead-reckoning distance unit
// Steps each command through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module tdrd_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tdrd_pkg::REQ_W-1:0]     req_type_i,
  input  logic                           end_of_program_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tdrd_pkg::dp_cmd_t              cmd_o,
  input  tdrd_pkg::dp_status_t           status_i
);

  typedef enum logic [10:0] {
    ST_IDLE    = 11'b000_0000_0001,
    ST_MUL_X   = 11'b000_0000_0010,
    ST_MUL_Y   = 11'b000_0000_0100,
    ST_ADD_Y   = 11'b000_0000_1000,
    ST_RECIP   = 11'b000_0001_0000,
    ST_TURN    = 11'b000_0010_0000,
    ST_SQ_LOAD = 11'b000_0100_0000,
    ST_SQUARE  = 11'b000_1000_0000,
    ST_RT_LOAD = 11'b001_0000_0000,
    ST_ROOT    = 11'b010_0000_0000,
    ST_ROUND   = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  tdrd_pkg::req_e   kind_q, kind_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    kind_d  = kind_q;
    last_d  = last_q;
    cmd_o.negate = (kind_q == tdrd_pkg::REQ_BACK);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          kind_d        = tdrd_pkg::req_e'(req_type_i);
          last_d        = end_of_program_i;
          if (req_type_i inside {tdrd_pkg::REQ_FWD, tdrd_pkg::REQ_BACK}) begin
            state_d = ST_MUL_X;
          end else begin
            state_d = ST_RECIP;
          end
        end
      end
      ST_MUL_X: begin
        cmd_o.mul_trig = 1'b1;
        cmd_o.trig_sin = 1'b1;
        state_d        = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd_o.add_x    = 1'b1;
        cmd_o.mul_trig = 1'b1;
        state_d        = ST_ADD_Y;
      end
      ST_ADD_Y: begin
        cmd_o.add_y = 1'b1;
        state_d     = last_q ? ST_SQ_LOAD : ST_IDLE;
      end
      ST_RECIP: begin
        cmd_o.mul_recip = 1'b1;
        state_d         = ST_TURN;
      end
      ST_TURN: begin
        cmd_o.turn_left  = (kind_q == tdrd_pkg::REQ_LEFT);
        cmd_o.turn_right = (kind_q == tdrd_pkg::REQ_RIGHT);
        state_d          = last_q ? ST_SQ_LOAD : ST_IDLE;
      end
      ST_SQ_LOAD: begin
        cmd_o.sq_load = 1'b1;
        state_d       = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.sq_step = 1'b1;
        if (status_i.step_last) begin
          state_d = ST_RT_LOAD;
        end
      end
      ST_RT_LOAD: begin
        cmd_o.rt_load = 1'b1;
        state_d       = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.rt_step = 1'b1;
        if (status_i.step_last) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // wait for the previous result to leave the output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      kind_q      <= tdrd_pkg::REQ_FWD;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/tdrd_dp.sv @@
// ----------------------------------------------------------------------------
// tdrd_dp : datapath of the turtle dead-reckoning distance unit
// Heading, saturating position, shared multiplier, serial squares and root.
// ----------------------------------------------------------------------------
module tdrd_dp #(
  parameter int FRAC_BITS   = tdrd_pkg::FRAC_BITS_DEF,
  parameter int AMOUNT_BITS = tdrd_pkg::AMOUNT_BITS_DEF,
  parameter int POS_BITS    = tdrd_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tdrd_pkg::dp_cmd_t               cmd_i,
  output tdrd_pkg::dp_status_t            status_o,
  input  logic [tdrd_pkg::AMT_W-1:0]      amount_i,
  output logic [tdrd_pkg::DIST_W-1:0]     distance_o,
  output logic                            saturated_o
);

  localparam int AW      = tdrd_pkg::AMT_W;
  localparam int HW      = tdrd_pkg::HEAD_W;
  localparam int PW      = tdrd_pkg::PROD_W;
  localparam int AMT_USE = (AMOUNT_BITS < AW) ? AMOUNT_BITS : AW;
  localparam int MAG_W   = 33;   // amount * trig plus rounding headroom
  localparam int SCL_W   = (FRAC_BITS >= 16) ? MAG_W + FRAC_BITS - 16 : MAG_W;
  localparam int DLT_W   = SCL_W + 1;
  localparam int SUM_W   = ((POS_BITS > DLT_W) ? POS_BITS : DLT_W) + 1;
  localparam int CNT_W   = $clog2(POS_BITS);
  localparam int RND_W   = ((POS_BITS + 1) > 33) ? POS_BITS + 1 : 33;

  localparam logic signed [SUM_W-1:0] POS_MAX =
    SUM_W'($signed({1'b0, {(POS_BITS-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] POS_MIN =
    SUM_W'($signed({1'b1, {(POS_BITS-1){1'b0}}}));

  // architectural state
  logic        [HW-1:0]        heading_q, heading_d;
  logic signed [POS_BITS-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic                        sat_q, sat_d;
  logic        [CNT_W-1:0]     cnt_q, cnt_d;

  // working registers
  logic [AW-1:0]               amt_q;
  logic                        trig_neg_q;
  logic [tdrd_pkg::TRIG_W-1:0] trig_mag_q;
  logic [PW-1:0]               prod_q;
  logic                        prod_neg_q;
  logic [POS_BITS-1:0]         mx_q, my_q, xs_q, ys_q, sq_lo_q;
  logic [POS_BITS:0]           sq_hi_q;
  logic [2*POS_BITS-1:0]       s_q;
  logic [POS_BITS+1:0]         r_q;
  logic [POS_BITS-1:0]         root_q;
  logic [tdrd_pkg::DIST_W-1:0] dist_q;
  logic                        sat_out_q;

  // --- trig lookup ---
  logic [HW:0]       cos_sum;
  logic [HW-1:0]     cos_ang, trig_ang;
  tdrd_pkg::trig_t   trig;

  always_comb begin
    cos_sum  = {1'b0, heading_q} + (HW+1)'(tdrd_pkg::QUARTER_TURN);
    cos_ang  = (cos_sum >= (HW+1)'(tdrd_pkg::FULL_TURN)) ?
               HW'(cos_sum - (HW+1)'(tdrd_pkg::FULL_TURN)) : cos_sum[HW-1:0];
    trig_ang = cmd_i.load_in ? cos_ang : heading_q;
    trig     = tdrd_pkg::trig_lookup(trig_ang);
  end

  // --- shared multiplier ---
  logic [tdrd_pkg::MUL_B_W-1:0] mul_b;
  logic [PW-1:0]                mul_p;

  always_comb begin
    mul_b = cmd_i.mul_recip ? tdrd_pkg::MUL_B_W'(tdrd_pkg::RECIP_VAL)
                            : {1'b0, trig_mag_q};
    mul_p = PW'(amt_q) * PW'(mul_b);
  end

  // --- move scaling ---
  logic [MAG_W-1:0] pmag;
  logic [SCL_W-1:0] scaled;

  assign pmag = prod_q[MAG_W-1:0];

  if (FRAC_BITS >= 16) begin : g_scale_up
    assign scaled = SCL_W'(pmag) << (FRAC_BITS - 16);
  end else begin : g_scale_down
    localparam int RSH = 16 - FRAC_BITS;
    assign scaled = (pmag + (MAG_W'(1) << (RSH - 1))) >> RSH;
  end

  // --- saturating accumulate, shared by x and y ---
  logic signed [DLT_W-1:0]    delta;
  logic signed [SUM_W-1:0]    acc_sum;
  logic signed [POS_BITS-1:0] acc_sel, acc_res;
  logic                       acc_sat;

  always_comb begin
    delta   = (prod_neg_q ^ cmd_i.negate) ? -$signed({1'b0, scaled})
                                          : $signed({1'b0, scaled});
    acc_sel = cmd_i.add_x ? pos_x_q : pos_y_q;
    acc_sum = SUM_W'(acc_sel) + SUM_W'(delta);
    acc_sat = 1'b1;
    if (acc_sum > POS_MAX) begin
      acc_res = POS_MAX[POS_BITS-1:0];
    end else if (acc_sum < POS_MIN) begin
      acc_res = POS_MIN[POS_BITS-1:0];
    end else begin
      acc_res = acc_sum[POS_BITS-1:0];
      acc_sat = 1'b0;
    end
  end

  // --- turn ---
  logic [tdrd_pkg::QUOT_W-1:0] quot;
  logic [AW-1:0]               turn_rem;
  logic [HW:0]                 head_sum;
  logic [HW-1:0]               head_new;

  always_comb begin
    quot     = prod_q[tdrd_pkg::RECIP_SHIFT +: tdrd_pkg::QUOT_W];
    turn_rem = amt_q - AW'(quot * AW'(tdrd_pkg::FULL_TURN));
    if (cmd_i.turn_left) begin
      head_sum = {1'b0, heading_q} + (HW+1)'(turn_rem[HW-1:0]);
    end else begin
      head_sum = {1'b0, heading_q} + (HW+1)'(tdrd_pkg::FULL_TURN)
               - (HW+1)'(turn_rem[HW-1:0]);
    end
    head_new = (head_sum >= (HW+1)'(tdrd_pkg::FULL_TURN)) ?
               HW'(head_sum - (HW+1)'(tdrd_pkg::FULL_TURN)) : head_sum[HW-1:0];
  end

  // --- sum of squares, LSB first, both axes together ---
  logic [POS_BITS-1:0] mag_x, mag_y;
  logic [POS_BITS:0]   sq_t;

  always_comb begin
    mag_x = pos_x_q[POS_BITS-1] ? (~pos_x_q + 1'b1) : pos_x_q;
    mag_y = pos_y_q[POS_BITS-1] ? (~pos_y_q + 1'b1) : pos_y_q;
    sq_t  = sq_hi_q + (POS_BITS+1)'(xs_q[0] ? mx_q : '0)
                    + (POS_BITS+1)'(ys_q[0] ? my_q : '0);
  end

  // --- restoring square root, two radicand bits a step ---
  logic [POS_BITS+1:0] r_sh, r_trial;
  logic                r_ge;

  always_comb begin
    r_sh    = {r_q[POS_BITS-1:0], s_q[2*POS_BITS-1 -: 2]};
    r_trial = {root_q, 2'b01};
    r_ge    = (r_sh >= r_trial);
  end

  // --- rounding of the root ---
  logic [RND_W-1:0] rnd_sum, rnd_shr;
  logic             rnd_sat;

  always_comb begin
    rnd_sum = RND_W'(root_q) + (RND_W'(1) << (FRAC_BITS - 1));
    rnd_shr = rnd_sum >> FRAC_BITS;
    rnd_sat = (rnd_shr > RND_W'(32'hFFFF_FFFF));
  end

  // --- state next values ---
  always_comb begin
    heading_d = heading_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    sat_d     = sat_q;
    cnt_d     = cnt_q;
    if (cmd_i.add_x) begin
      pos_x_d = acc_res;
      sat_d   = sat_q | acc_sat;
    end
    if (cmd_i.add_y) begin
      pos_y_d = acc_res;
      sat_d   = sat_q | acc_sat;
    end
    if (cmd_i.turn_left || cmd_i.turn_right) begin
      heading_d = head_new;
    end
    if (cmd_i.sq_load || cmd_i.rt_load) begin
      cnt_d = CNT_W'(POS_BITS - 1);
    end else if ((cmd_i.sq_step || cmd_i.rt_step) && (cnt_q != '0)) begin
      cnt_d = cnt_q - 1'b1;
    end
    if (cmd_i.out_load) begin
      heading_d = '0;
      pos_x_d   = '0;
      pos_y_d   = '0;
      sat_d     = 1'b0;
    end
  end

  assign status_o.step_last = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      sat_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      heading_q <= heading_d;
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      sat_q     <= sat_d;
      cnt_q     <= cnt_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      amt_q <= AW'(amount_i[AMT_USE-1:0]);
    end
    if (cmd_i.load_in || cmd_i.trig_sin) begin
      trig_neg_q <= trig.neg;
      trig_mag_q <= trig.mag;
    end
    if (cmd_i.mul_trig || cmd_i.mul_recip) begin
      prod_q     <= mul_p;
      prod_neg_q <= trig_neg_q;
    end
    if (cmd_i.sq_load) begin
      mx_q    <= mag_x;
      my_q    <= mag_y;
      xs_q    <= mag_x;
      ys_q    <= mag_y;
      sq_hi_q <= '0;
      sq_lo_q <= '0;
    end else if (cmd_i.sq_step) begin
      xs_q    <= xs_q >> 1;
      ys_q    <= ys_q >> 1;
      sq_hi_q <= {1'b0, sq_t[POS_BITS:1]};
      sq_lo_q <= {sq_t[0], sq_lo_q[POS_BITS-1:1]};
    end
    if (cmd_i.rt_load) begin
      s_q    <= {sq_hi_q[POS_BITS-1:0], sq_lo_q};
      r_q    <= '0;
      root_q <= '0;
    end else if (cmd_i.rt_step) begin
      s_q    <= s_q << 2;
      r_q    <= r_ge ? (r_sh - r_trial) : r_sh;
      root_q <= {root_q[POS_BITS-2:0], r_ge};
    end
    if (cmd_i.out_load) begin
      dist_q    <= rnd_sat ? '1 : rnd_shr[tdrd_pkg::DIST_W-1:0];
      sat_out_q <= sat_q;
    end
  end

  assign distance_o  = dist_q;
  assign saturated_o = sat_out_q;

endmodule

@@ design/turtle_dead_reckoning_distance_unit.sv @@
// ----------------------------------------------------------------------------
// turtle_dead_reckoning_distance_unit : turtle command dead reckoning
// Tracks heading and fixed-point position; reports distance from the origin.
// ----------------------------------------------------------------------------
// Takes one turtle command per input beat (forward, back, turn left, turn
// right) and keeps a heading in whole degrees and a saturating signed
// position with FRAC_BITS fraction bits in POS_BITS-bit accumulators. For a
// move the single 16x18 multiplier is used once for the cosine and once for
// the sine term, and one shared saturating adder updates x and then y. For a
// turn the same multiplier reduces the angle modulo 360 through a
// reciprocal, then the heading is wrapped. A command with end_of_program set
// is followed by a bit-serial sum of squares over POS_BITS steps, a
// restoring square root retiring one root bit a step, and a rounding step
// that loads the output register and clears heading, position and the
// saturation flag. The result beat then waits in the output register while
// further commands are accepted; only a second end of program stalls until
// the earlier result has been taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module turtle_dead_reckoning_distance_unit #(
  parameter int FRAC_BITS   = tdrd_pkg::FRAC_BITS_DEF,   // 8..24
  parameter int AMOUNT_BITS = tdrd_pkg::AMOUNT_BITS_DEF, // 8..24, low bits of amount used
  parameter int POS_BITS    = tdrd_pkg::POS_BITS_DEF     // 32..64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [tdrd_pkg::REQ_W-1:0]      req_type_i,
  input  logic [tdrd_pkg::AMT_W-1:0]      amount_i,
  input  logic                            end_of_program_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tdrd_pkg::DIST_W-1:0]     distance_o,
  output logic                            saturated_o
);

  // controller drives the command strobes; the datapath only reports
  // when its iteration counter has reached the last step
  tdrd_pkg::dp_cmd_t    cmd;
  tdrd_pkg::dp_status_t status;

  tdrd_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .req_type_i       (req_type_i),
    .end_of_program_i (end_of_program_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cmd_o            (cmd),
    .status_i         (status)
  );

  // the amount is captured in the datapath on the accepting edge, the command
  // kind and end flag in the controller
  tdrd_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .AMOUNT_BITS (AMOUNT_BITS),
    .POS_BITS    (POS_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .amount_i    (amount_i),
    .distance_o  (distance_o),
    .saturated_o (saturated_o)
  );

endmodule

@@ design/tdrd_checker.sv @@
// ----------------------------------------------------------------------------
// tdrd_checker : port-level checks for the distance unit
// Result count against end of program, busy time and output hold.
// ----------------------------------------------------------------------------
module tdrd_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic                            end_of_program_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic [tdrd_pkg::DIST_W-1:0]     distance_o,
  input  logic                            saturated_o
);

  logic       in_end_beat;
  logic       out_beat;
  logic [1:0] due_q, due_d;

  assign in_end_beat = in_valid_i && in_ready_o && end_of_program_i;
  assign out_beat    = out_valid_o && out_ready_i;

  // programs closed whose result beat has not been taken yet
  always_comb begin
    due_d = due_q;
    if (in_end_beat && !out_beat) begin
      due_d = due_q + 1'b1;
    end else if (!in_end_beat && out_beat) begin
      due_d = due_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q <= 2'd0;
    end else begin
      due_q <= due_d;
    end
  end

  // a result is only shown for a program that has been closed
  a_result_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (due_q != 2'd0))
    else $error("result without end of program");

  // at most one result waiting and one being worked out
  a_due_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    due_q != 2'd3)
    else $error("more than two results outstanding");

  // no command taken while a second result waits behind the first
  a_busy_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q == 2'd2) |-> !in_ready_o)
    else $error("command accepted with two results outstanding");

  // the unit is not ready in the cycle after any command beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready straight after a command beat");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(distance_o) && $stable(saturated_o)))
    else $error("stalled result changed");

endmodule

bind turtle_dead_reckoning_distance_unit tdrd_checker u_tdrd_checker (.*);
